// ===== rtl/assert_macros.svh =====
// Assertion macros used by the parser top level.
// No dependencies; each file that asserts includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/shffp_pkg.sv =====
// Package for the header / float frame parser: sizes, reset values,
// register indexes and the controller state type. No dependencies.
`timescale 1ns / 1ps

package shffp_pkg;

    localparam int FRAME_WORDS = 11;
    localparam int AW          = $clog2(FRAME_WORDS);
    localparam int IDX_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 31;

    localparam logic [7:0]  HEADER_RESET = 8'd65;
    localparam logic [30:0] LIMIT_RESET  = 31'd1232348144;
    localparam logic [31:0] ONE_BITS     = 32'h3F80_0000;
    localparam int          QUAT_WORDS   = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd1;

    typedef enum logic [2:0] {
        ST_HUNT1,
        ST_HUNT2,
        ST_LOAD,
        ST_EMIT_RD,
        ST_EMIT_WR
    } t_state;

endpackage

// ===== rtl/shffp_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module shffp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/sync_header_float_frame_parser.sv =====
// Top level of the header / float frame parser.
// Depends on shffp_pkg, shffp_ram and assert_macros.svh.
//
// Bytes are taken one per cycle while a frame is hunted or loaded: two header bytes, then
// FRAME_WORDS big-endian words, each stored in the frame RAM as its fourth byte arrives.
// After the final byte the input stalls while the words are read back and sanitized, one
// word at a time (RAM read, then output register load, which waits out any output stall).
// The quaternion check over words 0 to 3 is gathered during loading.
`timescale 1ns / 1ps

module sync_header_float_frame_parser (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_rx_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [shffp_pkg::IDX_W-1:0]     o_word_index,
    output logic [31:0]                     o_word_bits,
    output logic                            o_was_replaced,
    output logic                            o_last_word,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [shffp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [shffp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import shffp_pkg::*;
    `include "assert_macros.svh"

    localparam logic [AW-1:0] LAST_IDX = AW'(FRAME_WORDS - 1);

    t_state          r_state, n_state;
    logic [1:0]      r_byte_cnt, n_byte_cnt;
    logic [AW-1:0]   r_word_cnt, n_word_cnt;
    logic [23:0]     r_asm, n_asm;
    logic            r_quat_bad, n_quat_bad;
    logic [AW-1:0]   r_emit_idx, n_emit_idx;
    logic [7:0]      r_header;
    logic [30:0]     r_limit;

    logic            r_out_valid, n_out_valid;
    logic [IDX_W-1:0] r_out_idx, n_out_idx;
    logic [31:0]     r_out_bits, n_out_bits;
    logic            r_out_rep, n_out_rep;
    logic            r_out_last, n_out_last;

    logic            in_acc;
    logic            ram_wr_en, ram_rd_en;
    logic [31:0]     ram_wr_data, ram_rd_data;
    logic            rd_bad;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state == ST_EMIT_RD) || (r_state == ST_EMIT_WR);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign ram_wr_data = {r_asm, i_rx_byte};
    assign rd_bad      = ram_rd_data[30:0] > r_limit;

    shffp_ram #(
        .WIDTH(32),
        .DEPTH(FRAME_WORDS)
    ) u_frame_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_word_cnt),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_emit_idx),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_HUNT1;
            r_byte_cnt  <= '0;
            r_word_cnt  <= '0;
            r_asm       <= '0;
            r_quat_bad  <= 1'b0;
            r_emit_idx  <= '0;
            r_header    <= HEADER_RESET;
            r_limit     <= LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_byte_cnt  <= n_byte_cnt;
            r_word_cnt  <= n_word_cnt;
            r_asm       <= n_asm;
            r_quat_bad  <= n_quat_bad;
            r_emit_idx  <= n_emit_idx;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_HEADER: r_header <= i_cfg_data[7:0];
                    CFG_LIMIT:  r_limit  <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_idx  <= n_out_idx;
        r_out_bits <= n_out_bits;
        r_out_rep  <= n_out_rep;
        r_out_last <= n_out_last;
    end

    always_comb begin
        n_state     = r_state;
        n_byte_cnt  = r_byte_cnt;
        n_word_cnt  = r_word_cnt;
        n_asm       = r_asm;
        n_quat_bad  = r_quat_bad;
        n_emit_idx  = r_emit_idx;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_idx   = r_out_idx;
        n_out_bits  = r_out_bits;
        n_out_rep   = r_out_rep;
        n_out_last  = r_out_last;
        ram_wr_en   = 1'b0;
        ram_rd_en   = 1'b0;

        unique case (r_state)
            ST_HUNT2: begin
                if (in_acc) begin
                    if (i_rx_byte == r_header) begin
                        n_state    = ST_LOAD;
                        n_byte_cnt = '0;
                        n_word_cnt = '0;
                        n_asm      = '0;
                        n_quat_bad = 1'b0;
                    end else begin
                        n_state = ST_HUNT1;
                    end
                end
            end
            ST_LOAD: begin
                if (in_acc) begin
                    n_asm = {r_asm[15:0], i_rx_byte};
                    if (r_byte_cnt != 2'd3) begin
                        n_byte_cnt = r_byte_cnt + 2'd1;
                    end else begin
                        n_byte_cnt = '0;
                        ram_wr_en  = 1'b1;
                        if (r_word_cnt < AW'(QUAT_WORDS) && ram_wr_data[30:0] > r_limit) begin
                            n_quat_bad = 1'b1;
                        end
                        if (r_word_cnt == LAST_IDX) begin
                            n_word_cnt = '0;
                            n_emit_idx = '0;
                            n_state    = ST_EMIT_RD;
                        end else begin
                            n_word_cnt = r_word_cnt + AW'(1);
                        end
                    end
                end
            end
            ST_EMIT_RD: begin
                ram_rd_en = 1'b1;
                n_state   = ST_EMIT_WR;
            end
            ST_EMIT_WR: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = IDX_W'(r_emit_idx);
                    n_out_last  = (r_emit_idx == LAST_IDX);
                    if (r_emit_idx < AW'(QUAT_WORDS)) begin
                        n_out_rep  = r_quat_bad;
                        n_out_bits = !r_quat_bad ? ram_rd_data :
                                     (r_emit_idx == '0) ? ONE_BITS : 32'd0;
                    end else begin
                        n_out_rep  = rd_bad;
                        n_out_bits = rd_bad ? 32'd0 : ram_rd_data;
                    end
                    if (r_emit_idx == LAST_IDX) begin
                        n_state = ST_HUNT1;
                    end else begin
                        n_emit_idx = r_emit_idx + AW'(1);
                        n_state    = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                if (in_acc) begin
                    n_byte_cnt = '0;
                    n_state    = (i_rx_byte == r_header) ? ST_HUNT2 : ST_HUNT1;
                end
            end
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_word_index   = r_out_idx;
    assign o_word_bits    = r_out_bits;
    assign o_was_replaced = r_out_rep;
    assign o_last_word    = r_out_last;

    `ASSERT_IMPL(a_last_idx, i_clk, i_rst_n, o_out_valid && o_last_word,
        o_word_index == IDX_W'(FRAME_WORDS - 1))
    `ASSERT_IMPL(a_quat_one, i_clk, i_rst_n,
        o_out_valid && o_was_replaced && o_word_index == '0, o_word_bits == ONE_BITS)
    `ASSERT_NEXT(a_emit_start, i_clk, i_rst_n,
        in_acc && r_state == ST_LOAD && r_byte_cnt == 2'd3 && r_word_cnt == LAST_IDX,
        r_state == ST_EMIT_RD && r_emit_idx == '0)
    `ASSERT_NEXT(a_emit_step, i_clk, i_rst_n,
        r_state == ST_EMIT_WR && r_out_valid && i_out_stall,
        r_state == ST_EMIT_WR && $stable(r_emit_idx))

endmodule

// ===== sim/shffp_word_checker.sv =====
// Checker for the header / float frame parser: watches the byte, result and register
// channels, predicts every result word and compares it field by field.
// Depends on shffp_pkg.
`timescale 1ns / 1ps

module shffp_word_checker
    import shffp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [7:0]            i_rx_byte,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [IDX_W-1:0]      i_word_index,
    input  logic [31:0]           i_word_bits,
    input  logic                  i_was_replaced,
    input  logic                  i_last_word,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_words_pending,
    output logic                  o_hunting
);

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [31:0]      bits;
        logic             replaced;
        logic             last;
    } t_frame_word;

    t_frame_word expected_words[$];
    logic [7:0]  header_now;
    logic [30:0] limit_now;
    t_state      parse_state;
    logic [1:0]  byte_pos;
    int unsigned word_num;
    logic [31:0] assembly;
    logic [31:0] frame_buf[FRAME_WORDS];
    int          fail_count = 0;

    function automatic logic magnitude_over(logic [31:0] w);
        return w[30:0] > limit_now;
    endfunction

    task automatic report_mismatch(string msg);
        fail_count++;
        $display("%0t: %s", $realtime, msg);
    endtask

    task automatic queue_frame_words();
        logic        quat_bad;
        t_frame_word w;
        quat_bad = 1'b0;
        for (int i = 0; i < QUAT_WORDS; i++)
            if (magnitude_over(frame_buf[i])) quat_bad = 1'b1;
        for (int i = 0; i < FRAME_WORDS; i++) begin
            w.index    = IDX_W'(i);
            w.bits     = frame_buf[i];
            w.replaced = 1'b0;
            w.last     = (i == FRAME_WORDS - 1);
            if (i < QUAT_WORDS) begin
                if (quat_bad) begin
                    w.bits     = (i == 0) ? ONE_BITS : 32'd0;
                    w.replaced = 1'b1;
                end
            end else if (magnitude_over(w.bits)) begin
                w.bits     = 32'd0;
                w.replaced = 1'b1;
            end
            expected_words.push_back(w);
        end
    endtask

    task automatic take_rx_byte(logic [7:0] b);
        case (parse_state)
            ST_HUNT2: begin
                if (b == header_now) begin
                    parse_state = ST_LOAD;
                    byte_pos    = '0;
                    word_num    = 0;
                    assembly    = '0;
                end else begin
                    parse_state = ST_HUNT1;
                end
            end
            ST_LOAD: begin
                assembly = {assembly[23:0], b};
                if (byte_pos < 2'd3) begin
                    byte_pos++;
                end else begin
                    byte_pos            = '0;
                    frame_buf[word_num] = assembly;
                    assembly            = '0;
                    if (word_num + 1 >= FRAME_WORDS) begin
                        word_num    = 0;
                        parse_state = ST_HUNT1;
                        queue_frame_words();
                    end else begin
                        word_num++;
                    end
                end
            end
            default: begin
                byte_pos    = '0;
                parse_state = (b == header_now) ? ST_HUNT2 : ST_HUNT1;
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_frame_word want;
        if (!i_rst_n) begin
            header_now  = HEADER_RESET;
            limit_now   = LIMIT_RESET;
            parse_state = ST_HUNT1;
            byte_pos    = '0;
            word_num    = 0;
            assembly    = '0;
            expected_words.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_HEADER) header_now = i_cfg_data[7:0];
                else if (i_cfg_index == CFG_LIMIT) limit_now = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("word %0d bits %h with nothing expected",
                                              i_word_index, i_word_bits));
                end else begin
                    want = expected_words.pop_front();
                    if (i_word_index !== want.index)
                        report_mismatch($sformatf("word_index got %0d expected %0d",
                                                  i_word_index, want.index));
                    if (i_word_bits !== want.bits)
                        report_mismatch($sformatf("word %0d word_bits got %h expected %h",
                                                  want.index, i_word_bits, want.bits));
                    if (i_was_replaced !== want.replaced)
                        report_mismatch($sformatf("word %0d was_replaced got %b expected %b",
                                                  want.index, i_was_replaced, want.replaced));
                    if (i_last_word !== want.last)
                        report_mismatch($sformatf("word %0d last_word got %b expected %b",
                                                  want.index, i_last_word, want.last));
                end
            end
            if (i_in_valid && !i_in_stall) take_rx_byte(i_rx_byte);
        end
        o_fail_count    <= fail_count;
        o_words_pending <= expected_words.size();
        o_hunting       <= (parse_state == ST_HUNT1);
    end

endmodule

// ===== sim/sync_header_float_frame_parser_tb.sv =====
// Testbench top for the header / float frame parser: drives bytes, register writes and
// output stalls, and gives the verdict. Depends on shffp_pkg, shffp_word_checker and the RTL.
`timescale 1ns / 1ps

module sync_header_float_frame_parser_tb;
    import shffp_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 4 * FRAME_WORDS + 20;
    localparam int PHASE_BYTES   = 35;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam logic [30:0] INF_MAG = 31'h7F80_0000;
    localparam logic [30:0] NAN_MAG = 31'h7FC0_0000;
    localparam logic [30:0] MAG_MAX = 31'h7FFF_FFFF;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic [7:0]            i_rx_byte   = '0;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [IDX_W-1:0]      o_word_index;
    logic [31:0]           o_word_bits;
    logic                  o_was_replaced;
    logic                  o_last_word;
    logic                  o_cfg_ready;

    int          fail_count;
    int          words_pending;
    logic        parser_hunting;
    int          in_idle_pct   = 0;
    int          out_stall_pct = 0;
    int          cycle_count   = 0;
    logic [7:0]  stim_header   = HEADER_RESET;
    logic [30:0] stim_limit    = LIMIT_RESET;
    logic [31:0] frame_plan[FRAME_WORDS];

    sync_header_float_frame_parser uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_word_index   (o_word_index),
        .o_word_bits    (o_word_bits),
        .o_was_replaced (o_was_replaced),
        .o_last_word    (o_last_word),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    shffp_word_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_rx_byte       (i_rx_byte),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_word_index    (o_word_index),
        .i_word_bits     (o_word_bits),
        .i_was_replaced  (o_was_replaced),
        .i_last_word     (o_last_word),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_words_pending (words_pending),
        .o_hunting       (parser_hunting)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99, 0) < out_stall_pct);
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("sync_header_float_frame_parser_tb NOT OK");
        $finish;
    end

    task automatic push_rx_byte(logic [7:0] b);
        if ($urandom_range(99, 0) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99, 0) < in_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic push_planned_frame();
        push_rx_byte(stim_header);
        push_rx_byte(stim_header);
        for (int i = 0; i < FRAME_WORDS; i++)
            for (int k = 3; k >= 0; k--)
                push_rx_byte(frame_plan[i][8*k +: 8]);
    endtask

    function automatic logic [31:0] pick_word(bit keep_valid);
        logic [30:0] mag;
        logic [7:0]  expo;
        expo = 8'($urandom_range(150, 100));
        case ($urandom_range(9, 0))
            0: mag = stim_limit;
            1: mag = (stim_limit == MAG_MAX) ? MAG_MAX : stim_limit + 31'd1;
            2: mag = INF_MAG;
            3: mag = NAN_MAG | 31'($urandom_range(32'h003F_FFFF, 0));
            4: mag = '0;
            5: mag = MAG_MAX;
            6, 7: mag = {expo, 23'($urandom)};
            default: mag = 31'($urandom);
        endcase
        if (keep_valid && mag > stim_limit) mag = 31'($urandom_range(stim_limit, 0));
        return {1'($urandom_range(1, 0)), mag};
    endfunction

    task automatic plan_random_frame();
        bit clean_quat;
        clean_quat = ($urandom_range(99, 0) < 50);
        for (int i = 0; i < FRAME_WORDS; i++)
            frame_plan[i] = pick_word(i < QUAT_WORDS ? clean_quat
                                                     : ($urandom_range(99, 0) < 60));
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_HEADER) stim_header = data[7:0];
        else if (idx == CFG_LIMIT) stim_limit = data;
    endtask

    // finish any open frame, drain results, then let the emit logic go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (!parser_hunting) begin
            push_rx_byte(8'($urandom));
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        while (words_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random_phase(int byte_goal);
        int         sent;
        int         frames;
        int         kind;
        int         n;
        logic [7:0] b;
        sent   = 0;
        frames = 0;
        while (sent < byte_goal || frames == 0) begin
            kind = $urandom_range(99, 0);
            if (kind < 70) begin
                plan_random_frame();
                push_planned_frame();
                sent += 2 + 4 * FRAME_WORDS;
                frames++;
            end else if (kind < 80) begin
                n = $urandom_range(6, 1);
                repeat (n) push_rx_byte(8'($urandom));
                sent += n;
            end else if (kind < 90) begin
                do b = 8'($urandom); while (b == stim_header);
                push_rx_byte(stim_header);
                push_rx_byte(b);
                sent += 2;
            end else begin
                // truncated frame, later bytes fall into its payload
                n = $urandom_range(4 * FRAME_WORDS - 1, 1);
                push_rx_byte(stim_header);
                push_rx_byte(stim_header);
                repeat (n) push_rx_byte(8'($urandom));
                sent += n + 2;
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        in_idle_pct   = 28;
        out_stall_pct = 67;

        // directed: extreme bytes, second header byte wrong, then a frame of edge words
        push_rx_byte(8'h00);
        push_rx_byte(8'hFF);
        push_rx_byte(stim_header);
        push_rx_byte(stim_header + 8'd1);
        frame_plan[0]  = ONE_BITS;
        frame_plan[1]  = {1'b0, LIMIT_RESET + 31'd1};
        frame_plan[2]  = 32'h8000_0000;
        frame_plan[3]  = {1'b1, LIMIT_RESET};
        frame_plan[4]  = {1'b0, INF_MAG};
        frame_plan[5]  = {1'b1, NAN_MAG};
        frame_plan[6]  = 32'hFFFF_FFFF;
        frame_plan[7]  = {1'b0, LIMIT_RESET};
        frame_plan[8]  = {1'b1, LIMIT_RESET};
        frame_plan[9]  = 32'h0000_0000;
        frame_plan[10] = {1'b0, LIMIT_RESET + 31'd1};
        push_planned_frame();
        settle();

        write_register(CFG_HEADER, 31'd0);
        write_register(CFG_LIMIT, 31'd0);
        run_random_phase(PHASE_BYTES);
        settle();

        in_idle_pct   = 67;
        out_stall_pct = 28;
        write_register(CFG_HEADER, 31'h0000_00FF);
        write_register(CFG_LIMIT, INF_MAG);
        run_random_phase(PHASE_BYTES);
        settle();

        in_idle_pct   = 0;
        out_stall_pct = 0;
        write_register(CFG_SPARE_2, 31'($urandom));
        write_register(CFG_SPARE_3, 31'($urandom));
        write_register(CFG_HEADER, 31'($urandom_range(255, 0)));
        write_register(CFG_LIMIT, 31'($urandom));
        run_random_phase(PHASE_BYTES);
        settle();

        if (fail_count == 0) begin
            $display("sync_header_float_frame_parser_tb OK");
        end else begin
            $display("sync_header_float_frame_parser_tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/shffp_pkg.sv
rtl/shffp_ram.sv
rtl/sync_header_float_frame_parser.sv
sim/shffp_word_checker.sv
sim/sync_header_float_frame_parser_tb.sv
